@@ rtl/wsbv_pkg.sv @@
// ----------------------------------------------------------------------------
// wsbv_pkg
// Shared constants, types and the square root step of the wall boundary
// value pipeline.
// ----------------------------------------------------------------------------
package wsbv_pkg;

  localparam int DIMENSIONS = 3;
  localparam int LANES      = 3;

  // register indexes of the configuration port
  localparam logic [1:0] REG_MODE  = 2'd0;
  localparam logic [1:0] REG_ROUGH = 2'd1;
  localparam logic [1:0] REG_COEF  = 2'd2;

  localparam logic [30:0] ROUGH_RESET = 31'd65536;
  localparam logic [30:0] COEF_RESET  = 31'd491520;

  localparam logic [47:0] MAX48 = 48'hFFFF_FFFF_FFFF;

  localparam int NORM_DIV_STEPS = 63;
  localparam int AMAG_STEPS     = 32;
  localparam int YSQRT_STEPS    = 30;
  localparam int RATE_DIV_STEPS = 62;

  typedef struct packed {
    logic        mode;
    logic [30:0] rough;
    logic [30:0] coef;
  } cfg_t;

  typedef struct packed {
    logic [35:0] rem;
    logic [31:0] root;
  } sqrt_t;

  // one digit of a restoring square root: two radicand bits in, one root bit out
  function automatic sqrt_t sqrt_step(sqrt_t cur, logic [1:0] pair);
    logic [35:0] acc;
    logic [35:0] trial;
    sqrt_t       nx;
    acc   = {cur.rem[33:0], pair};
    trial = {2'b00, cur.root, 2'b01};
    if (acc >= trial) begin
      nx.rem  = acc - trial;
      nx.root = {cur.root[30:0], 1'b1};
    end else begin
      nx.rem  = acc;
      nx.root = {cur.root[30:0], 1'b0};
    end
    return nx;
  endfunction

endpackage

@@ rtl/wsbv_front.sv @@
// ----------------------------------------------------------------------------
// wsbv_front
// Squares of the vector components, wide products a^2 * s^2 from partial
// products, and the sums over the active dimensions. Four stages.
// ----------------------------------------------------------------------------
module wsbv_front (
  input  logic               clk,
  input  logic               rst,
  input  logic               advance,
  input  logic               in_valid,
  input  logic signed [31:0] area_x,
  input  logic signed [31:0] area_y,
  input  logic signed [31:0] area_z,
  input  logic signed [31:0] spacing_x,
  input  logic signed [31:0] spacing_y,
  input  logic signed [31:0] spacing_z,
  input  logic [30:0]        friction_velocity,
  output logic               valid,
  output logic [125:0]       nsum,
  output logic [63:0]        asum,
  output logic [30:0]        fvel
);

  localparam int L = wsbv_pkg::LANES;

  logic [31:0]  amag_in [L];
  logic [31:0]  smag_in [L];
  logic [63:0]  a2_full [L];
  logic [63:0]  s2_full [L];

  logic [3:0]   vld;
  logic [62:0]  a2 [L];
  logic [62:0]  s2 [L];
  logic [30:0]  fvel1, fvel2, fvel3;
  logic [63:0]  p_ll [L];
  logic [63:0]  p_lh [L];
  logic [63:0]  p_hl [L];
  logic [63:0]  p_hh [L];
  logic [63:0]  asum2, asum3;
  logic [125:0] lane_prod [L];
  logic [63:0]  asum_next;
  logic [125:0] nsum_next;

  always_comb begin
    amag_in[0] = area_x[31] ? (~area_x + 32'd1) : area_x;
    amag_in[1] = area_y[31] ? (~area_y + 32'd1) : area_y;
    amag_in[2] = area_z[31] ? (~area_z + 32'd1) : area_z;
    smag_in[0] = spacing_x[31] ? (~spacing_x + 32'd1) : spacing_x;
    smag_in[1] = spacing_y[31] ? (~spacing_y + 32'd1) : spacing_y;
    smag_in[2] = spacing_z[31] ? (~spacing_z + 32'd1) : spacing_z;
  end

  for (genvar d = 0; d < L; d++) begin : g_lane
    assign a2_full[d] = {32'b0, amag_in[d]} * {32'b0, amag_in[d]};
    assign s2_full[d] = {32'b0, smag_in[d]} * {32'b0, smag_in[d]};

    always_ff @(posedge clk) begin
      if (advance) begin
        a2[d]   <= a2_full[d][62:0];
        s2[d]   <= s2_full[d][62:0];
        p_ll[d] <= {33'b0, a2[d][30:0]} * {33'b0, s2[d][30:0]};
        p_lh[d] <= {33'b0, a2[d][30:0]} * {32'b0, s2[d][62:31]};
        p_hl[d] <= {32'b0, a2[d][62:31]} * {33'b0, s2[d][30:0]};
        p_hh[d] <= {32'b0, a2[d][62:31]} * {32'b0, s2[d][62:31]};
        if (d < wsbv_pkg::DIMENSIONS) begin
          lane_prod[d] <= {62'b0, p_ll[d]}
                        + (({62'b0, p_lh[d]} + {62'b0, p_hl[d]}) << 31)
                        + {p_hh[d], 62'b0};
        end else begin
          lane_prod[d] <= '0;
        end
      end
    end
  end

  always_comb begin
    asum_next = '0;
    nsum_next = '0;
    for (int d = 0; d < L; d++) begin
      if (d < wsbv_pkg::DIMENSIONS) begin
        asum_next = asum_next + {1'b0, a2[d]};
      end
      nsum_next = nsum_next + lane_prod[d];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (advance) begin
      vld <= {vld[2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      fvel1 <= friction_velocity;
      fvel2 <= fvel1;
      asum2 <= asum_next;
      fvel3 <= fvel2;
      asum3 <= asum2;
      fvel  <= fvel3;
      asum  <= asum3;
      nsum  <= nsum_next;
    end
  end

  assign valid = vld[3];

endmodule

@@ rtl/wsbv_norm.sv @@
// ----------------------------------------------------------------------------
// wsbv_norm
// Pipelined restoring divider sum(a^2 s^2) / sum(a^2), one quotient bit a
// stage, with the area magnitude square root in its first stages, then the
// square root that gives the projected wall distance.
// ----------------------------------------------------------------------------
module wsbv_norm (
  input  logic         clk,
  input  logic         rst,
  input  logic         advance,
  input  logic         in_valid,
  input  logic [125:0] nsum,
  input  logic [63:0]  asum,
  input  logic [30:0]  fvel_in,
  output logic         valid,
  output logic [31:0]  amag,
  output logic [31:0]  ysq,
  output logic         azero,
  output logic [30:0]  fvel
);

  localparam int ND = wsbv_pkg::NORM_DIV_STEPS;
  localparam int NY = wsbv_pkg::YSQRT_STEPS;

  typedef struct packed {
    logic [63:0]     rem;
    logic [62:0]     num;
    logic [62:0]     quo;
    logic [63:0]     asum;
    wsbv_pkg::sqrt_t sq;
    logic [63:0]     xrem;
    logic [30:0]     fvel;
  } dstage_t;

  typedef struct packed {
    wsbv_pkg::sqrt_t sq;
    logic [59:0]     xrem;
    logic [31:0]     amag;
    logic            azero;
    logic [30:0]     fvel;
  } ystage_t;

  dstage_t       dsrc [ND+1];
  dstage_t       dv   [ND];
  logic [ND-1:0] dv_valid;
  ystage_t       ysrc [NY+1];
  ystage_t       yv   [NY];
  logic [NY-1:0] yv_valid;

  assign dsrc[0] = '{rem: {1'b0, nsum[125:63]}, num: nsum[62:0], quo: '0, asum: asum,
                     sq: '0, xrem: asum, fvel: fvel_in};

  for (genvar k = 0; k < ND; k++) begin : g_div
    logic [64:0] acc;
    dstage_t     nx;

    always_comb begin
      acc     = {dsrc[k].rem, dsrc[k].num[62]};
      nx      = dsrc[k];
      nx.num  = {dsrc[k].num[61:0], 1'b0};
      if (acc >= {1'b0, dsrc[k].asum}) begin
        nx.rem = 64'(acc - {1'b0, dsrc[k].asum});
        nx.quo = {dsrc[k].quo[61:0], 1'b1};
      end else begin
        nx.rem = acc[63:0];
        nx.quo = {dsrc[k].quo[61:0], 1'b0};
      end
      if (k < wsbv_pkg::AMAG_STEPS) begin
        nx.sq   = wsbv_pkg::sqrt_step(dsrc[k].sq, dsrc[k].xrem[63:62]);
        nx.xrem = {dsrc[k].xrem[61:0], 2'b00};
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        dv_valid[k] <= 1'b0;
      end else if (advance) begin
        dv_valid[k] <= (k == 0) ? in_valid : dv_valid[(k == 0) ? 0 : k-1];
      end
    end

    always_ff @(posedge clk) begin
      if (advance) begin
        dv[k] <= nx;
      end
    end

    assign dsrc[k+1] = dv[k];
  end

  // the quotient drops its four fraction bits of the quarter spacing squared
  assign ysrc[0] = '{sq: '0, xrem: {1'b0, dsrc[ND].quo[62:4]}, amag: dsrc[ND].sq.root,
                     azero: (dsrc[ND].asum == 64'd0), fvel: dsrc[ND].fvel};

  for (genvar k = 0; k < NY; k++) begin : g_ysq
    ystage_t nx;

    always_comb begin
      nx      = ysrc[k];
      nx.sq   = wsbv_pkg::sqrt_step(ysrc[k].sq, ysrc[k].xrem[59:58]);
      nx.xrem = {ysrc[k].xrem[57:0], 2'b00};
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        yv_valid[k] <= 1'b0;
      end else if (advance) begin
        yv_valid[k] <= (k == 0) ? dv_valid[ND-1] : yv_valid[(k == 0) ? 0 : k-1];
      end
    end

    always_ff @(posedge clk) begin
      if (advance) begin
        yv[k] <= nx;
      end
    end

    assign ysrc[k+1] = yv[k];
  end

  assign valid = yv_valid[NY-1];
  assign amag  = ysrc[NY].amag;
  assign ysq   = ysrc[NY].sq.root;
  assign azero = ysrc[NY].azero;
  assign fvel  = ysrc[NY].fvel;

endmodule

@@ rtl/wsbv_rate.sv @@
// ----------------------------------------------------------------------------
// wsbv_rate
// Wall distance select, u* times coefficient, pipelined divide by the wall
// distance, saturation and the area weighting product.
// ----------------------------------------------------------------------------
module wsbv_rate (
  input  logic           clk,
  input  logic           rst,
  input  logic           advance,
  input  wsbv_pkg::cfg_t cfg,
  input  logic           in_valid,
  input  logic [31:0]    amag,
  input  logic [31:0]    ysq,
  input  logic           azero,
  input  logic [30:0]    fvel,
  output logic           valid,
  output logic [31:0]    area_magnitude,
  output logic [31:0]    wall_distance,
  output logic [47:0]    wall_sdr,
  output logic [47:0]    weighted_sdr,
  output logic           saturated
);

  localparam int NR = wsbv_pkg::RATE_DIV_STEPS;

  typedef struct packed {
    logic [31:0] rem;
    logic [61:0] num;
    logic [61:0] quo;
    logic [31:0] ydist;
    logic        zdiv;
    logic [31:0] amag;
  } rstage_t;

  logic [31:0]   y_sel;
  rstage_t       r0;
  logic          r0_valid;
  rstage_t       rsrc [NR+1];
  rstage_t       rv   [NR];
  logic [NR-1:0] rv_valid;

  logic          p_valid, m_valid;
  logic [47:0]   p_sdr, m_sdr;
  logic          p_sat, m_sat;
  logic [31:0]   p_y, m_y, p_amag, m_amag;
  logic [55:0]   m_lo, m_hi;
  logic [79:0]   wprod;
  logic          sdr_sat;

  assign y_sel = cfg.mode ? {1'b0, cfg.rough} : (azero ? 32'd0 : ysq);

  always_ff @(posedge clk) begin
    if (advance) begin
      r0.rem   <= '0;
      r0.num   <= {31'b0, fvel} * {31'b0, cfg.coef};
      r0.quo   <= '0;
      r0.ydist <= y_sel;
      r0.zdiv  <= azero || (y_sel == 32'd0);
      r0.amag  <= amag;
    end
  end

  assign rsrc[0] = r0;

  for (genvar k = 0; k < NR; k++) begin : g_div
    logic [32:0] acc;
    rstage_t     nx;

    always_comb begin
      acc    = {rsrc[k].rem, rsrc[k].num[61]};
      nx     = rsrc[k];
      nx.num = {rsrc[k].num[60:0], 1'b0};
      if (acc >= {1'b0, rsrc[k].ydist}) begin
        nx.rem = 32'(acc - {1'b0, rsrc[k].ydist});
        nx.quo = {rsrc[k].quo[60:0], 1'b1};
      end else begin
        nx.rem = acc[31:0];
        nx.quo = {rsrc[k].quo[60:0], 1'b0};
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        rv_valid[k] <= 1'b0;
      end else if (advance) begin
        rv_valid[k] <= (k == 0) ? r0_valid : rv_valid[(k == 0) ? 0 : k-1];
      end
    end

    always_ff @(posedge clk) begin
      if (advance) begin
        rv[k] <= nx;
      end
    end

    assign rsrc[k+1] = rv[k];
  end

  // zero area, zero divisor or a quotient past 48 bits clamps the rate
  assign sdr_sat = rsrc[NR].zdiv || (rsrc[NR].quo[61:48] != 14'd0);
  assign wprod   = {m_hi, 24'b0} + {24'b0, m_lo};

  always_ff @(posedge clk) begin
    if (rst) begin
      r0_valid <= 1'b0;
      p_valid  <= 1'b0;
      m_valid  <= 1'b0;
      valid    <= 1'b0;
    end else if (advance) begin
      r0_valid <= in_valid;
      p_valid  <= rv_valid[NR-1];
      m_valid  <= p_valid;
      valid    <= m_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      p_sdr          <= sdr_sat ? wsbv_pkg::MAX48 : rsrc[NR].quo[47:0];
      p_sat          <= sdr_sat;
      p_y            <= rsrc[NR].ydist;
      p_amag         <= rsrc[NR].amag;
      m_lo           <= {32'b0, p_sdr[23:0]} * {24'b0, p_amag};
      m_hi           <= {32'b0, p_sdr[47:24]} * {24'b0, p_amag};
      m_sdr          <= p_sdr;
      m_sat          <= p_sat;
      m_y            <= p_y;
      m_amag         <= p_amag;
      area_magnitude <= m_amag;
      wall_distance  <= m_y;
      wall_sdr       <= m_sdr;
      weighted_sdr   <= (wprod[79:64] != 16'd0) ? wsbv_pkg::MAX48 : wprod[63:16];
      saturated      <= m_sat || (wprod[79:64] != 16'd0);
    end
  end

endmodule

@@ rtl/wall_sdr_boundary_value.sv @@
// ----------------------------------------------------------------------------
// wall_sdr_boundary_value
// Wall boundary value of the specific dissipation rate for one wall-face
// integration point: area magnitude, wall distance, rate and weighted rate.
// ----------------------------------------------------------------------------
// Usage
//   Input channel in_valid / in_stall carries one integration point per
//   request; output channel out_valid / out_stall carries one result each.
//   A request is taken at a clock edge with valid high and stall low.
//   A point passes 4 stages of squares and wide products, 63 divider stages
//   (one quotient bit each, area magnitude root overlapped), 30 root stages
//   for the wall distance, the rate product, 62 divider stages and 3 stages
//   of clamp and weighting. Throughput is one request per cycle unless
//   stalled; the whole pipeline advances as one. When the receiver stalls a
//   waiting result, every stage holds and in_stall rises in the same cycle;
//   nothing is dropped or repeated. Synchronous reset clears all valid bits
//   and loads the register defaults (projected mode, roughness 1.0,
//   coefficient 7.5). The user must write registers via cfg_write_enable /
//   cfg_index / cfg_data only while idle; the block does not check.
// ----------------------------------------------------------------------------
module wall_sdr_boundary_value (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_write_enable,
  input  logic [1:0]         cfg_index,
  input  logic [30:0]        cfg_data,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [31:0] area_x,
  input  logic signed [31:0] area_y,
  input  logic signed [31:0] area_z,
  input  logic signed [31:0] spacing_x,
  input  logic signed [31:0] spacing_y,
  input  logic signed [31:0] spacing_z,
  input  logic [30:0]        friction_velocity,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [31:0]        area_magnitude,
  output logic [31:0]        wall_distance,
  output logic [47:0]        wall_sdr,
  output logic [47:0]        weighted_sdr,
  output logic               saturated
);

  wsbv_pkg::cfg_t cfg;
  logic           advance;

  logic           f_valid;
  logic [125:0]   f_nsum;
  logic [63:0]    f_asum;
  logic [30:0]    f_fvel;

  logic           n_valid;
  logic [31:0]    n_amag;
  logic [31:0]    n_ysq;
  logic           n_azero;
  logic [30:0]    n_fvel;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.mode  <= 1'b0;
      cfg.rough <= wsbv_pkg::ROUGH_RESET;
      cfg.coef  <= wsbv_pkg::COEF_RESET;
    end else if (cfg_write_enable) begin
      case (cfg_index)
        wsbv_pkg::REG_MODE:  cfg.mode  <= cfg_data[0];
        wsbv_pkg::REG_ROUGH: cfg.rough <= cfg_data;
        wsbv_pkg::REG_COEF:  cfg.coef  <= cfg_data;
        default: ;
      endcase
    end
  end

  // a stalled result freezes every stage
  assign advance  = !(out_valid && out_stall);
  assign in_stall = !advance;

  wsbv_front u_front (
    .clk               (clk),
    .rst               (rst),
    .advance           (advance),
    .in_valid          (in_valid),
    .area_x            (area_x),
    .area_y            (area_y),
    .area_z            (area_z),
    .spacing_x         (spacing_x),
    .spacing_y         (spacing_y),
    .spacing_z         (spacing_z),
    .friction_velocity (friction_velocity),
    .valid             (f_valid),
    .nsum              (f_nsum),
    .asum              (f_asum),
    .fvel              (f_fvel)
  );

  wsbv_norm u_norm (
    .clk      (clk),
    .rst      (rst),
    .advance  (advance),
    .in_valid (f_valid),
    .nsum     (f_nsum),
    .asum     (f_asum),
    .fvel_in  (f_fvel),
    .valid    (n_valid),
    .amag     (n_amag),
    .ysq      (n_ysq),
    .azero    (n_azero),
    .fvel     (n_fvel)
  );

  wsbv_rate u_rate (
    .clk            (clk),
    .rst            (rst),
    .advance        (advance),
    .cfg            (cfg),
    .in_valid       (n_valid),
    .amag           (n_amag),
    .ysq            (n_ysq),
    .azero          (n_azero),
    .fvel           (n_fvel),
    .valid          (out_valid),
    .area_magnitude (area_magnitude),
    .wall_distance  (wall_distance),
    .wall_sdr       (wall_sdr),
    .weighted_sdr   (weighted_sdr),
    .saturated      (saturated)
  );

endmodule

@@ rtl/wsbv_checker.sv @@
// ----------------------------------------------------------------------------
// wsbv_assertions
// Port level checks of the wall boundary value block.
// ----------------------------------------------------------------------------
module wsbv_assertions (
  input logic        clk,
  input logic        rst,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [31:0] area_magnitude,
  input logic [31:0] wall_distance,
  input logic [47:0] weighted_sdr,
  input logic        saturated
);

  // input side holds exactly when a result is held
  a_stall_link: assert property (@(posedge clk) disable iff (rst)
    in_stall == (out_valid && out_stall))
    else $error("input stall does not follow output stall");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid)
    else $error("stalled result dropped");

  a_zero_dist: assert property (@(posedge clk) disable iff (rst)
    out_valid && wall_distance == 32'd0 |-> saturated)
    else $error("zero wall distance without saturation");

  a_zero_area: assert property (@(posedge clk) disable iff (rst)
    out_valid && area_magnitude == 32'd0 |-> saturated && weighted_sdr == 48'd0)
    else $error("zero area result wrong");

  a_reset: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind wall_sdr_boundary_value wsbv_assertions u_wsbv_assertions (.*);

@@ test/wsbv_checker.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// wsbv_checker
// Watches the register port and both request channels of the wall boundary
// value block, computes the expected area magnitude, wall distance and rates
// for every accepted request and compares them with the returned results.
// ----------------------------------------------------------------------------
module wsbv_checker (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_write_enable,
  input  logic [1:0]         cfg_index,
  input  logic [30:0]        cfg_data,
  input  logic               in_valid,
  input  logic               in_stall,
  input  logic signed [31:0] area_x,
  input  logic signed [31:0] area_y,
  input  logic signed [31:0] area_z,
  input  logic signed [31:0] spacing_x,
  input  logic signed [31:0] spacing_y,
  input  logic signed [31:0] spacing_z,
  input  logic [30:0]        friction_velocity,
  input  logic               out_valid,
  input  logic               out_stall,
  input  logic [31:0]        area_magnitude,
  input  logic [31:0]        wall_distance,
  input  logic [47:0]        wall_sdr,
  input  logic [47:0]        weighted_sdr,
  input  logic               saturated,
  output int                 mismatches,
  output int                 pending,
  output int                 compared,
  output int                 saturated_seen
);

  typedef struct packed {
    logic [31:0] amag;
    logic [31:0] ydist;
    logic [47:0] rate;
    logic [47:0] weighted;
    logic        sat;
  } wall_value_t;

  wall_value_t          wall_values_due[$];
  wsbv_pkg::cfg_t       wall_cfg;

  function automatic logic [63:0] floor_root(input logic [127:0] x);
    logic [63:0] r;
    logic [63:0] c;
    r = '0;
    for (int i = 63; i >= 0; i--) begin
      c = r | (64'd1 << i);
      if ({64'd0, c} * {64'd0, c} <= x) r = c;
    end
    return r;
  endfunction

  function automatic logic [32:0] magnitude(input logic [31:0] v);
    return v[31] ? (33'h1_0000_0000 - {1'b0, v}) : {1'b0, v};
  endfunction

  function automatic wall_value_t predict_wall_value(input logic [31:0] a [3],
                                                     input logic [31:0] s [3],
                                                     input logic [30:0] ustar,
                                                     input wsbv_pkg::cfg_t cfg);
    logic [127:0] asum;
    logic [127:0] num;
    logic [127:0] a2;
    logic [127:0] s2;
    logic [127:0] rate;
    logic [127:0] prod;
    logic [63:0]  root;
    wall_value_t  r;
    asum = '0;
    num  = '0;
    r.sat = 1'b0;
    for (int d = 0; d < wsbv_pkg::DIMENSIONS; d++) begin
      a2 = magnitude(a[d]) * magnitude(a[d]);
      s2 = magnitude(s[d]) * magnitude(s[d]);
      asum += a2;
      num  += a2 * s2;
    end
    root   = floor_root(asum);
    r.amag = root[31:0];
    if (cfg.mode) begin
      r.ydist = {1'b0, cfg.rough};
    end else if (asum == 0) begin
      r.ydist = '0;
    end else begin
      root    = floor_root((num / asum) >> 4);
      r.ydist = root[31:0];
    end
    if (r.ydist == 0 || r.amag == 0) begin
      rate  = {80'd0, wsbv_pkg::MAX48};
      r.sat = 1'b1;
    end else begin
      rate = ({97'd0, ustar} * {97'd0, cfg.coef}) / r.ydist;
      if (rate > wsbv_pkg::MAX48) begin
        rate  = {80'd0, wsbv_pkg::MAX48};
        r.sat = 1'b1;
      end
    end
    r.rate = rate[47:0];
    prod = (rate * r.amag) >> 16;
    if (prod > wsbv_pkg::MAX48) begin
      prod  = {80'd0, wsbv_pkg::MAX48};
      r.sat = 1'b1;
    end
    r.weighted = prod[47:0];
    return r;
  endfunction

  task automatic check_field(input string name, input logic [47:0] want,
                             input logic [47:0] got);
    if (want !== got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endtask

  assign pending = wall_values_due.size();

  initial begin
    mismatches     = 0;
    compared       = 0;
    saturated_seen = 0;
  end

  always @(posedge clk) begin
    logic [31:0] a [3];
    logic [31:0] s [3];
    wall_value_t want;
    if (rst) begin
      wall_cfg <= '{mode: 1'b0, rough: wsbv_pkg::ROUGH_RESET, coef: wsbv_pkg::COEF_RESET};
      wall_values_due.delete();
    end else begin
      if (cfg_write_enable) begin
        case (cfg_index)
          wsbv_pkg::REG_MODE:  wall_cfg.mode  <= cfg_data[0];
          wsbv_pkg::REG_ROUGH: wall_cfg.rough <= cfg_data;
          wsbv_pkg::REG_COEF:  wall_cfg.coef  <= cfg_data;
          default: ;
        endcase
      end
      if (in_valid && !in_stall) begin
        a = '{area_x, area_y, area_z};
        s = '{spacing_x, spacing_y, spacing_z};
        wall_values_due.push_back(predict_wall_value(a, s, friction_velocity, wall_cfg));
      end
      if (out_valid && !out_stall) begin
        if (wall_values_due.size() == 0) begin
          $error("result with no request outstanding");
          mismatches++;
        end else begin
          want = wall_values_due.pop_front();
          check_field("area_magnitude", {16'd0, want.amag}, {16'd0, area_magnitude});
          check_field("wall_distance", {16'd0, want.ydist}, {16'd0, wall_distance});
          check_field("wall_sdr", want.rate, wall_sdr);
          check_field("weighted_sdr", want.weighted, weighted_sdr);
          check_field("saturated", {47'd0, want.sat}, {47'd0, saturated});
          compared++;
          if (want.sat) saturated_seen++;
        end
      end
    end
  end

endmodule

@@ test/tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Drives wall-face integration points into the wall boundary value block
// through directed corner cases and random phases under several idling
// patterns and register settings; the checker predicts and compares.
// ----------------------------------------------------------------------------
module tb;

  localparam int LATENCY    = 163;
  localparam int LONG_STALL = 600;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               cfg_write_enable = 1'b0;
  logic [1:0]         cfg_index = wsbv_pkg::REG_MODE;
  logic [30:0]        cfg_data = '0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic signed [31:0] area_x = '0, area_y = '0, area_z = '0;
  logic signed [31:0] spacing_x = '0, spacing_y = '0, spacing_z = '0;
  logic [30:0]        friction_velocity = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic [31:0]        area_magnitude, wall_distance;
  logic [47:0]        wall_sdr, weighted_sdr;
  logic               saturated;

  int mismatches, pending, compared, saturated_seen;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  logic long_hold_kick = 1'b0;
  int long_hold_left = 0;
  int points_sent = 0;

  always #5 clk = ~clk;

  wall_sdr_boundary_value u_dut (.*);

  wsbv_checker u_checker (.*);

  // receiver: random stalls, or one long hold-off counted here
  always @(posedge clk) begin
    if (long_hold_kick) begin
      long_hold_left <= LONG_STALL;
      out_stall      <= 1'b1;
    end else if (long_hold_left > 0) begin
      long_hold_left <= long_hold_left - 1;
      out_stall      <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  task automatic send_point(input logic [31:0] ax, ay, az, sx, sy, sz,
                            input logic [30:0] ustar);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid          <= 1'b1;
    area_x            <= ax;
    area_y            <= ay;
    area_z            <= az;
    spacing_x         <= sx;
    spacing_y         <= sy;
    spacing_z         <= sz;
    friction_velocity <= ustar;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    points_sent++;
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [30:0] val);
    cfg_write_enable <= 1'b1;
    cfg_index        <= idx;
    cfg_data         <= val;
    @(posedge clk);
    cfg_write_enable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_config(input logic mode, input logic [30:0] rough, coef);
    drain_results();
    write_reg(wsbv_pkg::REG_MODE, {30'd0, mode});
    write_reg(wsbv_pkg::REG_ROUGH, rough);
    write_reg(wsbv_pkg::REG_COEF, coef);
  endtask

  // moderate values so rates stay in range, mixed with extremes and full-range random values
  function automatic logic [31:0] rand_coord();
    case ($urandom_range(7))
      0: return 32'h8000_0000;
      1: return 32'h7FFF_FFFF;
      2: return '0;
      3, 4: return $urandom();
      default: return $signed($urandom_range(32'h0004_0000)) - 32'sh0002_0000;
    endcase
  endfunction

  function automatic logic [30:0] rand_ustar();
    case ($urandom_range(5))
      0: return 31'h7FFF_FFFF;
      1: return '0;
      2: return 31'($urandom());
      default: return 31'($urandom_range(32'h0002_0000));
    endcase
  endfunction

  task automatic random_phase(input int count, input int idle_pct, input int stall_pct);
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    repeat (count)
      send_point(rand_coord(), rand_coord(), rand_coord(), rand_coord(), rand_coord(),
                 rand_coord(), rand_ustar());
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset config: projected distance
    send_point(32'h0001_0000, 0, 0, 32'h0004_0000, 0, 0, 31'h0001_0000);
    send_point(0, 0, 0, 32'h0001_0000, 32'h0001_0000, 0, 31'h0001_0000);    // no area
    send_point(32'h0001_0000, 32'h0001_0000, 0, 0, 0, 0, 31'h0001_0000);    // zero spacing
    send_point(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
               32'h8000_0000, 32'h8000_0000, 31'h7FFF_FFFF);
    send_point(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
               32'h7FFF_FFFF, 32'h7FFF_FFFF, 31'h7FFF_FFFF);
    send_point(32'hFFFF_FFFF, 32'h0000_0001, 32'hFFFF_0000, 32'hFFFE_0000,
               32'h0003_0000, 32'hFFFF_FFFF, 31'h0);
    send_point(32'h0000_0001, 0, 0, 32'h0000_0004, 0, 0, 31'h7FFF_FFFF);    // rate overflow
    send_point(32'h7FFF_FFFF, 0, 0, 32'h0010_0000, 0, 0, 31'h0100_0000);   // large area
    send_point(0, 0, 32'h0002_0000, 0, 0, 32'hFFF0_0000, 31'h0000_8000);

    // rough wall with zero height
    set_config(1'b1, 31'd0, wsbv_pkg::COEF_RESET);
    send_point(32'h0001_0000, 0, 0, 32'h0004_0000, 0, 0, 31'h0001_0000);
    send_point(0, 0, 0, 32'h0004_0000, 0, 0, 31'h0001_0000);
    // rough wall with extreme height and coefficient
    set_config(1'b1, 31'h7FFF_FFFF, 31'h7FFF_FFFF);
    send_point(32'h0001_0000, 32'h0002_0000, 0, 0, 0, 0, 31'h7FFF_FFFF);
    send_point(32'h8000_0000, 0, 0, 0, 0, 0, 31'h0001_0000);
    set_config(1'b0, wsbv_pkg::ROUGH_RESET, 31'd0);
    send_point(32'h0001_0000, 0, 0, 32'h0004_0000, 0, 0, 31'h7FFF_FFFF);
    send_point(32'h0003_0000, 32'hFFFC_0000, 0, 32'h0001_0000, 32'h0002_0000, 0,
               31'h0001_0000);

    set_config(1'b0, wsbv_pkg::ROUGH_RESET, wsbv_pkg::COEF_RESET);
    random_phase(100, 0, 0);
    // long receiver hold-off while requests keep coming
    long_hold_kick <= 1'b1;
    @(posedge clk);
    long_hold_kick <= 1'b0;
    random_phase(150, 0, 0);
    set_config(1'b1, 31'($urandom_range(32'h0010_0000)), 31'($urandom()));
    random_phase(80, 56, 0);
    set_config(1'b0, 31'($urandom()), 31'h7FFF_FFFF);
    random_phase(80, 0, 56);
    set_config(1'b1, 31'h7FFF_FFFF, 31'd1);
    random_phase(50, 17, 17);
    set_config(1'b0, wsbv_pkg::ROUGH_RESET, wsbv_pkg::COEF_RESET);
    random_phase(50, 17, 17);

    drain_results();
    recv_stall_pct = 0;
    repeat (LATENCY + 20) @(posedge clk);
    $display("sent %0d integration points, %0d results compared, %0d saturated",
             points_sent, compared, saturated_seen);
    $display("covered both distance modes, register extremes and four idling patterns");
    if (mismatches == 0 && pending == 0)
      $display("PASS");
    else
      $display("FAIL");
    $finish;
  end

  initial begin
    #5ms;
    $display("FAIL");
    $finish;
  end

endmodule

@@ filelist.f @@
rtl/wsbv_pkg.sv
rtl/wsbv_front.sv
rtl/wsbv_norm.sv
rtl/wsbv_rate.sv
rtl/wall_sdr_boundary_value.sv
rtl/wsbv_checker.sv
test/wsbv_checker.sv
test/tb.sv
